// ----- src/fraction_add_reduce_core_macros.svh -----
// Assertion macros shared by the checkers of the fraction adder.
// Needs nothing else; included by the checker file.
`ifndef FRACTION_ADD_REDUCE_CORE_MACROS_SVH
`define FRACTION_ADD_REDUCE_CORE_MACROS_SVH

// Same-cycle implication, checked once reset has been released.
`define FAR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked once reset has been released.
`define FAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/far_pkg.sv -----
// Types and constants shared by the fraction adder modules.
// Depends on nothing; compiled first.
package far_pkg;

  localparam int unsigned NUM_BITS = 33;
  localparam int unsigned DEN_BITS = 31;

  typedef enum logic [1:0] {
    MUL_AD,
    MUL_CB,
    MUL_BD
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_GCD,
    DIV_NUM,
    DIV_DEN
  } div_src_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum_en;
    logic     zero_res;
    logic     gcd_init;
    logic     gcd_next;
    logic     div_start;
    div_src_e div_src;
    logic     num_save;
    logic     den_save;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mn_zero;
    logic gy_zero;
    logic div_busy;
    logic div_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/far_in_if.sv -----
// Input channel of the fraction adder: valid, ready and two fractions per word.
// Depends on nothing.
interface far_in_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] num_a;
  logic signed [W-1:0] den_a;
  logic signed [W-1:0] num_b;
  logic signed [W-1:0] den_b;

  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

// ----- src/far_out_if.sv -----
// Output channel of the fraction adder: valid, ready and one reduced sum per word.
// Depends on nothing.
interface far_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] sum_num;
  logic [30:0]        sum_den;
  logic               div_zero;

  modport source (output valid, sum_num, sum_den, div_zero, input ready);
  modport sink (input valid, sum_num, sum_den, div_zero, output ready);
endinterface

// ----- src/far_div.sv -----
// Shared restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on nothing; used by the datapath.
module far_div #(
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [DW:0]   trial, diff;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      rem_d = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      quo_d = {quo_q[DW-2:0], ~diff[DW]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ----- src/far_ctrl.sv -----
// Sequencing state machine of the fraction adder; drives the datapath commands.
// Depends on far_pkg.
module far_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  far_pkg::dp_sts_t  sts_i,
  output far_pkg::dp_cmd_t  cmd_o
);
  import far_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_MUL_AD    = 13'h0002,
    S_MUL_CB    = 13'h0004,
    S_MUL_BD    = 13'h0008,
    S_SUM       = 13'h0010,
    S_CHECK     = 13'h0020,
    S_GCD_TEST  = 13'h0040,
    S_GCD_WAIT  = 13'h0080,
    S_NUM_START = 13'h0100,
    S_NUM_WAIT  = 13'h0200,
    S_DEN_START = 13'h0400,
    S_DEN_WAIT  = 13'h0800,
    S_DONE      = 13'h1000
  } state_e;

  state_e  state_q, state_d;
  dp_cmd_t cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_MUL_AD;
        end
      end
      S_MUL_AD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AD;
        state_d     = S_MUL_CB;
      end
      S_MUL_CB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CB;
        state_d     = S_MUL_BD;
      end
      S_MUL_BD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BD;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.div_zero || sts_i.mn_zero) begin
          cmd.zero_res = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_d      = S_GCD_TEST;
        end
      end
      S_GCD_TEST: begin
        if (sts_i.gy_zero) begin
          state_d = S_NUM_START;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_GCD;
          state_d       = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd.gcd_next = 1'b1;
          state_d      = S_GCD_TEST;
        end
      end
      S_NUM_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_NUM;
        state_d       = S_NUM_WAIT;
      end
      S_NUM_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd.num_save = 1'b1;
          state_d      = S_DEN_START;
        end
      end
      S_DEN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_DEN;
        state_d       = S_DEN_WAIT;
      end
      S_DEN_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd.den_save = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;
endmodule

// ----- src/far_dp.sv -----
// Datapath of the fraction adder: operand split, shared multiplier, signed sum,
// Euclid registers, shared divider and output register. Depends on far_pkg, far_div.
module far_dp #(
  parameter int unsigned W = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  far_pkg::dp_cmd_t                 cmd_i,
  output far_pkg::dp_sts_t                 sts_o,
  input  logic signed [W-1:0]              num_a_i,
  input  logic signed [W-1:0]              den_a_i,
  input  logic signed [W-1:0]              num_b_i,
  input  logic signed [W-1:0]              den_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [far_pkg::NUM_BITS-1:0] sum_num_o,
  output logic [far_pkg::DEN_BITS-1:0]     sum_den_o,
  output logic                             div_zero_o
);
  import far_pkg::*;

  localparam int unsigned PW = 2 * W;
  localparam int unsigned XW = (PW + 1 > NUM_BITS) ? PW + 1 : NUM_BITS;

  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic          sa_q, sda_q, sc_q, sdb_q, dz_q, sn_q;
  logic [W-1:0]  ma_q, mda_q, mc_q, mdb_q;
  logic [PW-1:0] p1_q, p2_q, mn_q, md_q, gx_q, gy_q;

  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] mul_p;
  logic          s1, s2, sum_neg;
  logic [PW-1:0] sum_mag;
  logic [PW-1:0] div_a, div_b, div_quo, div_rem;
  logic          div_busy;

  logic [XW-1:0] num_ext, num_sgn, den_ext;
  logic          out_valid_q;
  logic [NUM_BITS-1:0] sum_num_q;
  logic [DEN_BITS-1:0] sum_den_q;
  logic          div_zero_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AD: begin
        mul_x = ma_q;
        mul_y = mdb_q;
      end
      MUL_CB: begin
        mul_x = mc_q;
        mul_y = mda_q;
      end
      default: begin
        mul_x = mda_q;
        mul_y = mdb_q;
      end
    endcase
  end

  assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  always_comb begin
    s1 = sa_q ^ sdb_q;
    s2 = sc_q ^ sda_q;
    if (s1 == s2) begin
      sum_mag = p1_q + p2_q;
      sum_neg = s1;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = s1;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = s2;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
    if (sda_q != sdb_q) begin
      sum_neg = ~sum_neg;
    end
  end

  always_comb begin
    case (cmd_i.div_src)
      DIV_GCD: begin
        div_a = gx_q;
        div_b = gy_q;
      end
      DIV_NUM: begin
        div_a = mn_q;
        div_b = gx_q;
      end
      default: begin
        div_a = md_q;
        div_b = gx_q;
      end
    endcase
  end

  far_div #(
    .DW(PW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .busy_o    (div_busy),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sa_q  <= num_a_i[W-1];
      sda_q <= den_a_i[W-1];
      sc_q  <= num_b_i[W-1];
      sdb_q <= den_b_i[W-1];
      ma_q  <= mag_of(num_a_i);
      mda_q <= mag_of(den_a_i);
      mc_q  <= mag_of(num_b_i);
      mdb_q <= mag_of(den_b_i);
      dz_q  <= (den_a_i == '0) || (den_b_i == '0);
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_AD:  p1_q <= mul_p;
        MUL_CB:  p2_q <= mul_p;
        default: md_q <= mul_p;
      endcase
    end
    if (cmd_i.sum_en) begin
      mn_q <= sum_mag;
      sn_q <= sum_neg;
    end
    if (cmd_i.zero_res) begin
      mn_q <= '0;
      md_q <= PW'(1);
      sn_q <= 1'b0;
    end
    if (cmd_i.gcd_init) begin
      gx_q <= mn_q;
      gy_q <= md_q;
    end
    if (cmd_i.gcd_next) begin
      gx_q <= gy_q;
      gy_q <= div_rem;
    end
    if (cmd_i.num_save) begin
      mn_q <= div_quo;
    end
    if (cmd_i.den_save) begin
      md_q <= div_quo;
    end
  end

  always_comb begin
    num_ext = XW'(mn_q);
    num_sgn = sn_q ? (~num_ext + 1'b1) : num_ext;
    den_ext = XW'(md_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sum_num_q  <= num_sgn[NUM_BITS-1:0];
      sum_den_q  <= den_ext[DEN_BITS-1:0];
      div_zero_q <= dz_q;
    end
  end

  assign sts_o.mn_zero  = (mn_q == '0);
  assign sts_o.gy_zero  = (gy_q == '0);
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_zero = dz_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign sum_num_o   = sum_num_q;
  assign sum_den_o   = sum_den_q;
  assign div_zero_o  = div_zero_q;
endmodule

// ----- src/fraction_add_reduce_core.sv -----
// Top level of the fraction adder: adds a/b and c/d and reduces the sum to lowest terms.
// Depends on far_pkg, far_in_if, far_out_if, far_ctrl and far_dp.
//
// The input channel takes one word of two signed fractions; the output channel
// gives one word per input: the reduced numerator (carrying the sign), a positive
// denominator and a flag that is set when an input denominator was zero, in which
// case the result is 0/1. A zero sum is always given as 0/1.
// One word is worked on at a time. After a word is accepted, three products on the
// shared multiplier, a sum and a check follow; then the shared divider runs the
// Euclid remainders and the two final divisions. A zero or error result skips the
// divider. The next word can be accepted in the cycle after the result is loaded
// into the output register, which waits until that register is free.
// The divider is used for every Euclid step in turn.
// The result is held in an output register; while the receiver stalls, the word
// stays there, and the block may take the next word but waits in its final state before it loads that result.
// Reset empties the output register and returns the controller to idle.
module fraction_add_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  far_in_if.sink    in_i,
  far_out_if.source out_o
);
  import far_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  far_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  far_dp #(
    .W(OPERAND_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .num_a_i    (in_i.num_a),
    .den_a_i    (in_i.den_a),
    .num_b_i    (in_i.num_b),
    .den_b_i    (in_i.den_b),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sum_num_o  (out_o.sum_num),
    .sum_den_o  (out_o.sum_den),
    .div_zero_o (out_o.div_zero)
  );

  assign in_i.ready = in_ready;
endmodule

// ----- src/far_chk.sv -----
// Port checker of the fraction adder, bound to the top level.
// Depends on fraction_add_reduce_core_macros.svh.
`include "fraction_add_reduce_core_macros.svh"

module far_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [32:0] sum_num_i,
  input logic [30:0]        sum_den_i,
  input logic               div_zero_i
);
  `FAR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(sum_num_i) && $stable(sum_den_i) && $stable(div_zero_i),
    "stalled output word changed")
  `FAR_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i,
    "input taken while a word is in progress")
  `FAR_ASSERT_IMPL(a_den_positive, clk_i, rst_ni, out_valid_i, sum_den_i != 31'd0,
    "denominator of result is zero")
  `FAR_ASSERT_IMPL(a_zero_form, clk_i, rst_ni,
    out_valid_i && (div_zero_i || sum_num_i == 33'sd0),
    sum_num_i == 33'sd0 && sum_den_i == 31'd1,
    "zero or error result not given as 0/1")
endmodule

bind fraction_add_reduce_core far_chk u_far_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .sum_num_i  (out_o.sum_num),
  .sum_den_i  (out_o.sum_den),
  .div_zero_i (out_o.div_zero)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for fraction_add_reduce_core: directed sums, then random ones.
// Depends on far_pkg, far_in_if, far_out_if and the core; each word is checked against
// its listed sum or a local exact-arithmetic model of the reduced sum.
module testbench;

  import far_pkg::*;

  localparam int unsigned W            = 16;
  localparam int          RANDOM_WORDS = 550;
  localparam int          QUIET_WORDS  = 60;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam bit          KNOWN        = 1'b1;
  localparam bit          PREDICT      = 1'b0;

  typedef struct packed {
    logic signed [W-1:0] num_a;
    logic signed [W-1:0] den_a;
    logic signed [W-1:0] num_b;
    logic signed [W-1:0] den_b;
  } fracs_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] sum_num;
    logic [DEN_BITS-1:0]        sum_den;
    logic                       div_zero;
  } sum_t;

  typedef struct {
    fracs_t op;
    bit     typed;
    sum_t   want;
  } row_t;

  logic clk;
  logic rst_n;

  far_in_if #(.W(W)) in_if ();
  far_out_if         out_if ();

  fraction_add_reduce_core #(
    .OPERAND_WIDTH(W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  sum_t sums_due[$];
  row_t directed_sums[$];
  int   words_sent;
  int   sums_checked;
  int   div_zero_sums;
  int   zero_sums;
  int   failures;
  bit   held_off;

  function automatic longint euclid_gcd(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic sum_t reduce_sum(fracs_t op);
    longint na, da, nb, db, top, bot, g;
    sum_t   s;
    na = $signed(op.num_a);
    da = $signed(op.den_a);
    nb = $signed(op.num_b);
    db = $signed(op.den_b);
    s  = '0;
    s.sum_den = DEN_BITS'(1);
    if (da == 0 || db == 0) begin
      s.div_zero = 1'b1;
      return s;
    end
    top = na * db + nb * da;
    bot = da * db;
    if (bot < 0) begin
      top = -top;
      bot = -bot;
    end
    if (top == 0) return s;
    g   = euclid_gcd(top < 0 ? -top : top, bot);
    top = top / g;
    bot = bot / g;
    s.sum_num = top[NUM_BITS-1:0];
    s.sum_den = bot[DEN_BITS-1:0];
    return s;
  endfunction

  function automatic row_t mk_row(int na, int da, int nb, int db, bit typed,
                                  longint en, longint ed, bit ez);
    row_t r;
    r.op.num_a      = na[W-1:0];
    r.op.den_a      = da[W-1:0];
    r.op.num_b      = nb[W-1:0];
    r.op.den_b      = db[W-1:0];
    r.typed         = typed;
    r.want.sum_num  = en[NUM_BITS-1:0];
    r.want.sum_den  = ed[DEN_BITS-1:0];
    r.want.div_zero = ez;
    return r;
  endfunction

  function automatic logic signed [W-1:0] pick_corner();
    case ($urandom_range(0, 6))
      0:       return W'(-32768);
      1:       return W'(-32767);
      2:       return W'(-1);
      3:       return W'(0);
      4:       return W'(1);
      5:       return W'(32766);
      default: return W'(32767);
    endcase
  endfunction

  function automatic fracs_t random_fracs();
    fracs_t f;
    int     mode;
    int     mag;
    mode = $urandom_range(0, 99);
    f    = {$urandom, $urandom};
    if (mode < 5) begin
      if ($urandom_range(0, 1)) f.den_a = '0;
      else f.den_b = '0;
    end else if (mode < 13) begin
      mag     = $urandom_range(1, 32767);
      f.num_a = W'(int'($urandom_range(0, 65534)) - 32767);
      f.den_a = $urandom_range(0, 1) ? W'(mag) : W'(-mag);
      if ($urandom_range(0, 1)) begin
        f.num_b = -f.num_a;
        f.den_b = f.den_a;
      end else begin
        f.num_b = f.num_a;
        f.den_b = -f.den_a;
      end
    end else if (mode < 33) begin
      f.num_a = W'(int'($urandom_range(0, 40)) - 20);
      f.den_a = W'(int'($urandom_range(0, 40)) - 20);
      f.num_b = W'(int'($urandom_range(0, 40)) - 20);
      f.den_b = W'(int'($urandom_range(0, 40)) - 20);
    end else if (mode < 43) begin
      f.num_a = pick_corner();
      f.den_a = pick_corner();
      f.num_b = pick_corner();
      f.den_b = pick_corner();
    end
    return f;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // The receiver stalls in short bursts, and once holds off long enough to back up the input.
  initial begin
    out_if.ready <= 1'b0;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && words_sent >= 120) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (words_sent < directed_sums.size() + RANDOM_WORDS - QUIET_WORDS &&
                   $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sum_t got;
    sum_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.sum_num, out_if.sum_den, out_if.div_zero};
      if (sums_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: num %0d den %0d div_zero %0b",
                   got.sum_num, got.sum_den, got.div_zero);
      end else begin
        want = sums_due.pop_front();
        sums_checked++;
        if (want.div_zero) div_zero_sums++;
        else if (want.sum_num == 0) zero_sums++;
        if (got.sum_num !== want.sum_num || got.sum_den !== want.sum_den ||
            got.div_zero !== want.div_zero) begin
          failures++;
          if (failures <= 10)
            $display("mismatch on sum %0d: expected %0d/%0d dz %0b, got %0d/%0d dz %0b",
                     sums_checked, want.sum_num, want.sum_den, want.div_zero,
                     got.sum_num, got.sum_den, got.div_zero);
        end
      end
    end
  end

  initial begin
    row_t r;
    int   n_total;
    int   gap;
    words_sent    = 0;
    sums_checked  = 0;
    div_zero_sums = 0;
    zero_sums     = 0;
    failures      = 0;
    in_if.valid <= 1'b0;
    in_if.num_a <= '0;
    in_if.den_a <= '0;
    in_if.num_b <= '0;
    in_if.den_b <= '0;

    directed_sums.push_back(mk_row(0, 1, 0, 1, KNOWN, 0, 1, 0));
    directed_sums.push_back(mk_row(1, 0, 1, 1, KNOWN, 0, 1, 1));
    directed_sums.push_back(mk_row(1, 1, 1, 0, KNOWN, 0, 1, 1));
    directed_sums.push_back(mk_row(0, 0, 0, 0, KNOWN, 0, 1, 1));
    directed_sums.push_back(mk_row(-32768, 0, 32767, -32768, KNOWN, 0, 1, 1));
    directed_sums.push_back(mk_row(-32768, -32768, -32768, -32768, KNOWN, 2, 1, 0));
    directed_sums.push_back(mk_row(32767, 1, 32767, 1, KNOWN, 65534, 1, 0));
    directed_sums.push_back(mk_row(-32768, 1, -32768, 1, KNOWN, -65536, 1, 0));
    directed_sums.push_back(mk_row(-32768, -1, -32768, -1, KNOWN, 65536, 1, 0));
    directed_sums.push_back(mk_row(32767, 32767, -32768, -32768, KNOWN, 2, 1, 0));
    directed_sums.push_back(mk_row(1, -2, 1, 2, KNOWN, 0, 1, 0));
    directed_sums.push_back(mk_row(3, 5, -3, 5, KNOWN, 0, 1, 0));
    directed_sums.push_back(mk_row(-5, -7, 5, -7, KNOWN, 0, 1, 0));
    directed_sums.push_back(mk_row(0, -32768, 0, -32768, KNOWN, 0, 1, 0));
    directed_sums.push_back(mk_row(1, 2, 1, 3, KNOWN, 5, 6, 0));
    directed_sums.push_back(mk_row(1, 2, 1, 2, KNOWN, 1, 1, 0));
    directed_sums.push_back(mk_row(1, -2, 1, -3, KNOWN, -5, 6, 0));
    directed_sums.push_back(mk_row(0, -1, 3, -4, KNOWN, -3, 4, 0));
    directed_sums.push_back(mk_row(17711, 28657, 0, 1, PREDICT, 0, 0, 0));
    directed_sums.push_back(mk_row(32767, -32768, -32768, 32767, PREDICT, 0, 0, 0));
    directed_sums.push_back(mk_row(1, -32768, 1, -32768, PREDICT, 0, 0, 0));
    directed_sums.push_back(mk_row(-32768, 32767, -32768, 32767, PREDICT, 0, 0, 0));
    directed_sums.push_back(mk_row(12345, -32767, -1, 3, PREDICT, 0, 0, 0));
    n_total = directed_sums.size() + RANDOM_WORDS;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int i = 0; i < n_total; i++) begin
      if (i < directed_sums.size()) begin
        r = directed_sums[i];
      end else begin
        r.op    = random_fracs();
        r.typed = PREDICT;
        r.want  = '0;
      end
      gap = 0;
      if (i < n_total - QUIET_WORDS && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.num_a <= r.op.num_a;
      in_if.den_a <= r.op.den_a;
      in_if.num_b <= r.op.num_b;
      in_if.den_b <= r.op.den_b;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      sums_due.push_back(r.typed ? r.want : reduce_sum(r.op));
      words_sent++;
    end
    in_if.valid <= 1'b0;

    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d reduced sums from %0d input words", sums_checked, words_sent);
    $display("%0d with a zero denominator, %0d zero sums, one %0d-cycle output hold-off",
             div_zero_sums, zero_sums, HOLD_CYCLES);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule
